// File: sv/lkv_pkg.sv
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int DATA_W  = 32;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch item, clear scan trackers
        logic scan;    // examine entry at idx
        logic update;  // commit state, register result
        idx_t idx;
        idx_t rd_idx;  // entry fetched from the store for the next cycle
    } dp_cmd_t;

endpackage

// File: sv/lkv_ctrl.sv
module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    idx_t   idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (idx_reg == idx_t'(ENTRIES - 1))
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    idx_next = idx_reg + idx_t'(1);
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // fetch one entry ahead so its data is registered when idx reaches it
        cmd.rd_idx = idx_next;
    end

endmodule

// File: sv/lkv_dpath.sv
module lkv_dpath
    import lkv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_data,
    input  logic                     opcode,
    input  logic signed [DATA_W-1:0] lookup_key,
    input  logic signed [DATA_W-1:0] write_value,
    output logic                     done,
    output logic                     hit,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     evicted,
    output logic signed [DATA_W-1:0] evicted_key
);

    logic [DATA_W-1:0] keys_mem [ENTRIES];
    logic [DATA_W-1:0] vals_mem [ENTRIES];

    logic [ENTRIES-1:0] valid_reg, valid_next;
    rank_t              rank_reg  [ENTRIES];
    rank_t              rank_next [ENTRIES];
    cnt_t               count_reg, count_next;
    logic [CAP_W-1:0]   capacity_reg;

    // latched item
    logic              op_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] val_reg;

    // store read data
    logic [DATA_W-1:0] rd_key_reg;
    logic [DATA_W-1:0] rd_val_reg;

    // scan trackers
    logic              found_vld_reg;
    idx_t              found_idx_reg;
    rank_t             found_rank_reg;
    logic [DATA_W-1:0] found_val_reg;
    logic              best_vld_reg;
    idx_t              best_idx_reg;
    rank_t             best_rank_reg;
    logic [DATA_W-1:0] best_key_reg;
    logic              free_vld_reg;
    idx_t              free_idx_reg;

    // result
    logic              done_reg;
    logic              hit_reg;
    logic [DATA_W-1:0] rd_reg;
    logic              ev_reg;
    logic [DATA_W-1:0] evkey_reg;

    logic [DATA_W-1:0] cur_key;
    logic [DATA_W-1:0] cur_val;
    rank_t             cur_rank;
    logic              cur_valid;
    logic              cur_match;

    cnt_t  limit;
    logic  set_hit;
    logic  ins;
    logic  do_evict;
    logic  ins_ok;
    idx_t  slot;

    assign cur_key   = rd_key_reg;
    assign cur_val   = rd_val_reg;
    assign cur_rank  = rank_reg[cmd.idx];
    assign cur_valid = valid_reg[cmd.idx];
    assign cur_match = cur_valid && (cur_key == key_reg);

    // capacity clamped to 1 .. ENTRIES
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            limit = cnt_t'(1);
        end
        else if (int'(capacity_reg) > ENTRIES)
        begin
            limit = cnt_t'(ENTRIES);
        end
        else
        begin
            limit = cnt_t'(capacity_reg);
        end
    end

    assign set_hit  = (op_reg == OP_SET) && found_vld_reg;
    assign ins      = (op_reg == OP_SET) && !found_vld_reg;
    assign do_evict = ins && (count_reg >= limit) && best_vld_reg;
    assign ins_ok   = do_evict || (ins && free_vld_reg);
    assign slot     = do_evict ? best_idx_reg : free_idx_reg;

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        if (cmd.update)
        begin
            if (set_hit)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && (rank_reg[i] < found_rank_reg))
                    begin
                        rank_next[i] = rank_reg[i] + rank_t'(1);
                    end
                    if (idx_t'(i) == found_idx_reg)
                    begin
                        rank_next[i] = '0;
                    end
                end
            end
            else if (ins_ok)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (idx_t'(i) == slot)
                    begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + rank_t'(1);
                    end
                end
                if (!do_evict)
                begin
                    count_next = count_reg + cnt_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            count_reg    <= '0;
            capacity_reg <= CAP_W'(ENTRIES);
            done_reg     <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
            done_reg  <= cmd.update;
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // key/value store, no reset; read one entry ahead of the walk
    always_ff @(posedge clk)
    begin
        rd_key_reg <= keys_mem[cmd.rd_idx];
        rd_val_reg <= vals_mem[cmd.rd_idx];
        if (cmd.update && set_hit)
        begin
            vals_mem[found_idx_reg] <= val_reg;
        end
        else if (cmd.update && ins_ok)
        begin
            keys_mem[slot] <= key_reg;
            vals_mem[slot] <= val_reg;
        end
    end

    // item latch, scan trackers, result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_vld_reg <= 1'b0;
            best_vld_reg  <= 1'b0;
            free_vld_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            found_vld_reg <= 1'b0;
            best_vld_reg  <= 1'b0;
            free_vld_reg  <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (!found_vld_reg && cur_match)
            begin
                found_vld_reg <= 1'b1;
            end
            if (cur_valid)
            begin
                best_vld_reg <= 1'b1;
            end
            if (!cur_valid)
            begin
                free_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            key_reg <= lookup_key;
            val_reg <= write_value;
        end
        if (cmd.scan)
        begin
            if (!found_vld_reg && cur_match)
            begin
                found_idx_reg  <= cmd.idx;
                found_rank_reg <= cur_rank;
                found_val_reg  <= cur_val;
            end
            if (cur_valid && (!best_vld_reg || (cur_rank > best_rank_reg)))
            begin
                best_idx_reg  <= cmd.idx;
                best_rank_reg <= cur_rank;
                best_key_reg  <= cur_key;
            end
            if (!cur_valid && !free_vld_reg)
            begin
                free_idx_reg <= cmd.idx;
            end
        end
        if (cmd.update)
        begin
            hit_reg   <= found_vld_reg;
            rd_reg    <= (op_reg == OP_SET) ? '0 :
                         (found_vld_reg ? found_val_reg : '1);
            ev_reg    <= do_evict;
            evkey_reg <= do_evict ? best_key_reg : '0;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = rd_reg;
    assign evicted     = ev_reg;
    assign evicted_key = evkey_reg;

endmodule

// File: sv/lru_key_value_cache_unit.sv
// LRU key-value cache: sixteen fully associative entries. Pulse start with
// an item (get or set) while busy is low; the result appears on the result
// ports for exactly one cycle with done high, and must be taken then, as
// nothing holds it. An item is latched when start is taken, then the entries are
// walked one per cycle through the single key/value read port, and then the
// update is committed. The result shows in
// the cycle after the commit, which is also the first cycle a new start is
// taken. A get leaves recency alone; a set on a present key refreshes it; a
// set on a new key fills a free entry or, when the clamped capacity (1..16)
// is reached, replaces the least recent entry and reports its key. The
// capacity port is always ready; write it only while the block is idle.
module lru_key_value_cache_unit
    import lkv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // item in
    input  logic                     start,
    output logic                     busy,
    input  logic                     opcode,
    input  logic signed [DATA_W-1:0] lookup_key,
    input  logic signed [DATA_W-1:0] write_value,
    // result out
    output logic                     done,
    output logic                     hit,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     evicted,
    output logic signed [DATA_W-1:0] evicted_key,
    // capacity register
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_W-1:0]         cfg_data
);

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // sequencer: idle, entry walk, commit
    lkv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // entry store, recency ranks, scan trackers and result registers
    lkv_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

    // a result only ever follows a cycle of work
    a_done_after_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)
    ) else $error("result without an item in flight");

    // an accepted item takes the block busy at once
    a_accept_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy
    ) else $error("item accepted but block not busy");

    // eviction only on a missed set, which reads zero
    a_evict_miss: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> (!hit && (read_value == '0))
    ) else $error("eviction reported on a hit or a get");

    // no eviction, no victim key
    a_evkey_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && !evicted) |-> (evicted_key == '0)
    ) else $error("victim key without eviction");

endmodule

// File: tb/sv/lru_key_value_cache_unit_tb.sv
`timescale 1ns / 1ps

module lru_key_value_cache_unit_tb
    import lkv_pkg::*;
();

    // One reply per accepted item, in acceptance order
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [DATA_W-1:0] evicted_key;
    } cache_reply_t;

    // Shadow copy of the cache contents plus the queue of replies still owed.
    // Ranks follow the block's convention: 0 is most recent, live entries hold
    // 0 .. live_count-1 with no repeats.
    class lru_tracker;
        logic [DATA_W-1:0] slot_key   [ENTRIES];
        logic [DATA_W-1:0] slot_value [ENTRIES];
        bit                slot_live  [ENTRIES];
        int unsigned       slot_age   [ENTRIES];
        int unsigned       live_count;
        int unsigned       cap_reg;
        cache_reply_t      owed_replies[$];
        int unsigned       errors;

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_live[i]  = 1'b0;
                slot_age[i]   = 0;
            end
            live_count = 0;
            cap_reg    = 16;
            errors     = 0;
        endfunction

        function void set_capacity(input logic [CAP_W-1:0] v);
            cap_reg = 32'(v);
        endfunction

        // clamp as the hardware does: 0 behaves as 1, anything past the array size as full
        function int unsigned held_limit();
            if (cap_reg < 1)
                return 1;
            if (cap_reg > ENTRIES)
                return ENTRIES;
            return cap_reg;
        endfunction

        function void age_live(input int unsigned bound);
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i] && slot_age[i] < bound)
                    slot_age[i]++;
        endfunction

        function int unsigned outstanding();
            return owed_replies.size();
        endfunction

        // Work out the reply to an accepted item and update the shadow state
        function void take_request(input logic op, input logic [DATA_W-1:0] key,
                                   input logic [DATA_W-1:0] val);
            cache_reply_t r;
            int           found;
            int           slot;
            int unsigned  oldest;
            r     = '0;
            found = -1;
            slot  = -1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (found < 0 && slot_live[i] && slot_key[i] == key)
                    found = i;
            end
            r.hit = (found >= 0);
            if (op == OP_GET)
            begin
                r.read_value = (found >= 0) ? slot_value[found] : '1;
            end
            else if (found >= 0)
            begin
                // refresh: only entries newer than this one age, and this one becomes the head
                slot_value[found] = val;
                age_live(slot_age[found]);
                slot_age[found] = 0;
            end
            else
            begin
                if (live_count >= held_limit())
                begin
                    oldest = 0;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (slot_live[i] && (slot < 0 || slot_age[i] > oldest))
                        begin
                            slot   = i;
                            oldest = slot_age[i];
                        end
                    end
                    if (slot >= 0)
                    begin
                        r.evicted     = 1'b1;
                        r.evicted_key = slot_key[slot];
                        slot_live[slot] = 1'b0;
                        live_count--;
                    end
                end
                if (slot < 0)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot < 0 && !slot_live[i])
                            slot = i;
                end
                if (slot >= 0)
                begin
                    age_live(32'hFFFF_FFFF);
                    slot_key[slot]   = key;
                    slot_value[slot] = val;
                    slot_age[slot]   = 0;
                    slot_live[slot]  = 1'b1;
                    live_count++;
                end
            end
            owed_replies.push_back(r);
        endfunction

        task report_mismatch(input string what, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] want);
            if (errors < 50)
                $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_response(input cache_reply_t got);
            cache_reply_t want;
            if (owed_replies.size() == 0)
            begin
                report_mismatch("reply with nothing outstanding", got.read_value, '0);
            end
            else
            begin
                want = owed_replies.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch("hit", DATA_W'(got.hit), DATA_W'(want.hit));
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", got.read_value, want.read_value);
                if (got.evicted !== want.evicted)
                    report_mismatch("evicted", DATA_W'(got.evicted), DATA_W'(want.evicted));
                if (got.evicted_key !== want.evicted_key)
                    report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
            end
        endtask
    endclass

    localparam int KEY_POOL = 24;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     opcode;
    logic signed [DATA_W-1:0] lookup_key;
    logic signed [DATA_W-1:0] write_value;
    logic                     done;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [DATA_W-1:0] evicted_key;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_data;

    lru_tracker        tracker;
    logic [DATA_W-1:0] key_pool [KEY_POOL];
    int unsigned       pool_span;   // how much of the key pool the random items draw on
    int unsigned       idle_pct;    // chance in a hundred that the sender idles before an item

    lru_key_value_cache_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Everything is observed at the rising edge, before the block's own updates land.
    // The reply is checked first: a new item may be taken at the very edge that
    // ends the previous reply's cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_response('{hit, read_value, evicted, evicted_key});
            if (start && !busy)
                tracker.take_request(opcode, lookup_key, write_value);
            if (cfg_valid && cfg_ready)
                tracker.set_capacity(cfg_data);
        end
    end

    // Present one item from a falling edge and hold it until the block takes it.
    // An optional idle stretch first, long enough to land in any phase of the
    // walk.
    task automatic send_item(input logic op, input logic [DATA_W-1:0] key,
                             input logic [DATA_W-1:0] val);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clk);
        end
        start       = 1'b1;
        opcode      = op;
        lookup_key  = key;
        write_value = val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic wait_replies_in();
        while (tracker.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // capacity only changes with the block idle: every owed reply has come back first
    task automatic write_capacity(input logic [CAP_W-1:0] v);
        wait_replies_in();
        repeat (2) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        // keep the working set a little wider than what fits, so hits and evictions both occur
        if (v == 0)
            pool_span = 3;
        else if (v > ENTRIES)
            pool_span = ENTRIES + 4;
        else
            pool_span = v + 3;
    endtask

    task automatic run_random(input int n_items);
        logic              op;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] val;
        for (int i = 0; i < n_items; i++)
        begin
            op = ($urandom_range(1) == 1) ? OP_SET : OP_GET;
            if ($urandom_range(99) < 82)
                key = key_pool[$urandom_range(pool_span - 1)];
            else
                key = $urandom;
            case ($urandom_range(9))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = '1;
                default: val = $urandom;
            endcase
            send_item(op, key, val);
        end
    endtask

    logic [CAP_W-1:0] cap_plan [18];
    int unsigned      phase_idle [3];
    int unsigned      waited;

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        opcode      = OP_GET;
        lookup_key  = '0;
        write_value = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        idle_pct    = 0;
        pool_span   = ENTRIES + 4;
        tracker     = new();

        // pool holds the key extremes plus random keys
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int i = 4; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        cap_plan   = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd0, 5'd4,
                       5'd3, 5'd17, 5'd8, 5'd1, 5'd16, 5'd5,
                       5'd12, 5'd2, 5'd31, 5'd15, 5'd6, 5'd16};
        phase_idle = '{8, 53, 0};

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, at the reset capacity of sixteen first
        send_item(OP_GET, 32'h0000_0000, 32'h1234_5678);   // lookup in an empty cache
        send_item(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_SET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(OP_SET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(OP_GET, 32'h8000_0000, 32'h0);
        send_item(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_SET, 32'hFFFF_FFFF, 32'h0000_0005);   // update of the head: ranks untouched
        send_item(OP_SET, 32'h8000_0000, 32'h0000_0007);   // update of an older entry moves it up
        send_item(OP_GET, 32'h0000_3039, 32'h0);           // miss on an absent key

        // capacity dropped under the live count: one eviction per insert, count held
        write_capacity(5'd2);
        send_item(OP_SET, 32'h0000_0064, 32'h1);
        send_item(OP_SET, 32'h0000_00C8, 32'h2);
        send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);

        // zero behaves as one
        write_capacity(5'd0);
        send_item(OP_SET, 32'h0000_012C, 32'h3);
        send_item(OP_SET, 32'h0000_012C, 32'h4);
        send_item(OP_GET, 32'h0000_012C, 32'h0);
        send_item(OP_SET, 32'h0000_0190, 32'h5);

        // capacity of one: every new key evicts the least recent entry
        write_capacity(5'd1);
        send_item(OP_SET, 32'h0000_01F4, 32'h6);
        send_item(OP_GET, 32'h0000_0190, 32'h0);
        send_item(OP_SET, 32'hFFFF_FE0C, 32'h7);

        // above the array size behaves as sixteen
        write_capacity(5'd31);
        send_item(OP_SET, 32'h0000_0258, 32'h8);
        send_item(OP_GET, 32'hFFFF_FE0C, 32'h0);

        // Random part: sender idles lightly, then heavily, then not at all.
        // Each block starts from a fresh capacity with the block drained.
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = phase_idle[ph];
            for (int blk = 0; blk < 6; blk++)
            begin
                write_capacity(cap_plan[ph * 6 + blk]);
                run_random(80);
            end
        end

        // drain, with a bound of its own
        waited = 0;
        while (tracker.outstanding() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (tracker.outstanding() != 0)
            tracker.report_mismatch("replies never returned", tracker.outstanding(), '0);
        repeat (40) @(posedge clk);

        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hard stop: far beyond the slowest legitimate run
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
sv/lkv_pkg.sv
sv/lkv_ctrl.sv
sv/lkv_dpath.sv
sv/lru_key_value_cache_unit.sv
tb/sv/lru_key_value_cache_unit_tb.sv
